// ===== design/utf8dec_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8dec_pkg
// shared constants for the utf-8 decoder with line and column tracking
// ----------------------------------------------------------------------------
package utf8dec_pkg;

  localparam int unsigned CP_BITS   = 31;
  localparam int unsigned POS_W     = 32;

  typedef logic [CP_BITS-1:0] cp_t;
  typedef logic [1:0]         status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_STRAY = 2'd1;
  localparam status_t ST_TRUNC = 2'd2;
  localparam status_t ST_END   = 2'd3;

  localparam cp_t LF_CODE = 31'h0A;
  localparam cp_t CR_CODE = 31'h0D;

  localparam logic [7:0] LEAD6_MASK = 8'hFC;
  localparam logic [7:0] LEAD5_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_MASK = 8'hC0;
  localparam logic [7:0] CONT_MASK  = 8'h80;
  localparam logic [7:0] LOW6_MASK  = 8'h3F;

endpackage

// ===== design/utf8_decoder_with_line_tracking_core.sv =====
// ----------------------------------------------------------------------------
// utf8_decoder_with_line_tracking_core
// path: input register, then result register; throughput: one byte per cycle
// unless the result side stalls, set by the single-pass decode between the two
// registers. bytes that open or extend a sequence without ending it give no result.
// reset: synchronous active-low rst_n clears the sequence state, the cr/lf
// flags and the valid bits, and sets line and column to 1.
// ----------------------------------------------------------------------------
module utf8_decoder_with_line_tracking_core #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [30:0] code_point, [62:31] line_number,
                                  // [94:63] column_number, [95] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eoi_r;

  // decoder state
  utf8dec_pkg::cp_t         partial_r, partial_nxt;
  logic [2:0]               rem_r, rem_nxt;
  logic                     cr_r, cr_nxt;
  logic                     lf_r, lf_nxt;
  logic [POSITION_BITS-1:0] line_r, line_nxt;
  logic [POSITION_BITS-1:0] col_r, col_nxt;

  // result register
  logic                     out_valid_r;
  utf8dec_pkg::cp_t         out_cp_r;
  logic [31:0]              out_line_r;
  logic [31:0]              out_col_r;
  utf8dec_pkg::status_t     out_status_r;

  logic                     res_valid;
  utf8dec_pkg::cp_t         res_cp;
  utf8dec_pkg::status_t     res_status;
  logic                     done;
  utf8dec_pkg::cp_t         done_cp;
  utf8dec_pkg::cp_t         shifted;
  logic                     new_line;
  logic [31:0]              line_out;
  logic [31:0]              col_out;
  logic                     out_free;
  logic                     s1_go;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!res_valid || out_free);
  assign in_tready = !s1_valid_r || s1_go;

  assign shifted = {partial_r[utf8dec_pkg::CP_BITS-7:0], s1_byte_r[5:0]};

  always_comb begin
    partial_nxt = partial_r;
    rem_nxt     = rem_r;
    res_valid   = 1'b0;
    res_cp      = '0;
    res_status  = utf8dec_pkg::ST_OK;
    done        = 1'b0;
    done_cp     = '0;
    if (s1_eoi_r) begin
      res_valid   = 1'b1;
      res_status  = (rem_r != 3'd0) ? utf8dec_pkg::ST_TRUNC : utf8dec_pkg::ST_END;
      partial_nxt = '0;
      rem_nxt     = 3'd0;
    end else if (rem_r != 3'd0) begin
      rem_nxt = rem_r - 3'd1;
      if (rem_r == 3'd1) begin
        done        = 1'b1;
        done_cp     = shifted;
        partial_nxt = '0;
      end else begin
        partial_nxt = shifted;
      end
    end else if ((s1_byte_r & utf8dec_pkg::CONT_MASK) == 8'h00) begin
      done    = 1'b1;
      done_cp = utf8dec_pkg::CP_BITS'(s1_byte_r);
    end else if ((s1_byte_r & utf8dec_pkg::LEAD6_MASK) == utf8dec_pkg::LEAD6_MASK) begin
      partial_nxt = utf8dec_pkg::CP_BITS'(s1_byte_r[1:0]);
      rem_nxt     = 3'd5;
    end else if ((s1_byte_r & utf8dec_pkg::LEAD5_MASK) == utf8dec_pkg::LEAD5_MASK) begin
      partial_nxt = utf8dec_pkg::CP_BITS'(s1_byte_r[1:0]);
      rem_nxt     = 3'd4;
    end else if ((s1_byte_r & utf8dec_pkg::LEAD4_MASK) == utf8dec_pkg::LEAD4_MASK) begin
      partial_nxt = utf8dec_pkg::CP_BITS'(s1_byte_r[2:0]);
      rem_nxt     = 3'd3;
    end else if ((s1_byte_r & utf8dec_pkg::LEAD3_MASK) == utf8dec_pkg::LEAD3_MASK) begin
      partial_nxt = utf8dec_pkg::CP_BITS'(s1_byte_r[3:0]);
      rem_nxt     = 3'd2;
    end else if ((s1_byte_r & utf8dec_pkg::LEAD2_MASK) == utf8dec_pkg::LEAD2_MASK) begin
      partial_nxt = utf8dec_pkg::CP_BITS'(s1_byte_r[4:0]);
      rem_nxt     = 3'd1;
    end else begin
      res_valid  = 1'b1;
      res_status = utf8dec_pkg::ST_STRAY;
    end
    if (done) begin
      res_valid = 1'b1;
      res_cp    = done_cp;
    end
  end

  // line and column update
  always_comb begin
    line_nxt = line_r;
    col_nxt  = col_r;
    cr_nxt   = cr_r;
    lf_nxt   = lf_r;
    new_line = ((done_cp == utf8dec_pkg::LF_CODE) && !cr_r) ||
               ((done_cp == utf8dec_pkg::CR_CODE) && !lf_r);
    if (s1_eoi_r) begin
      cr_nxt = 1'b0;
      lf_nxt = 1'b0;
    end else if (done) begin
      if (new_line) begin
        line_nxt = (line_r == POS_MAX) ? POS_MAX : line_r + POS_ONE;
        col_nxt  = POS_ONE;
      end else begin
        col_nxt  = (col_r == POS_MAX) ? POS_MAX : col_r + POS_ONE;
      end
      cr_nxt = (done_cp == utf8dec_pkg::CR_CODE);
      lf_nxt = (done_cp == utf8dec_pkg::LF_CODE);
    end
  end

  generate
    if (POSITION_BITS >= utf8dec_pkg::POS_W) begin : g_pos_trunc
      assign line_out = line_nxt[31:0];
      assign col_out  = col_nxt[31:0];
    end else begin : g_pos_ext
      assign line_out = {{(utf8dec_pkg::POS_W-POSITION_BITS){1'b0}}, line_nxt};
      assign col_out  = {{(utf8dec_pkg::POS_W-POSITION_BITS){1'b0}}, col_nxt};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      partial_r   <= '0;
      rem_r       <= 3'd0;
      cr_r        <= 1'b0;
      lf_r        <= 1'b0;
      line_r      <= POS_ONE;
      col_r       <= POS_ONE;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_go && res_valid;
      end
      if (s1_go) begin
        partial_r <= partial_nxt;
        rem_r     <= rem_nxt;
        cr_r      <= cr_nxt;
        lf_r      <= lf_nxt;
        line_r    <= line_nxt;
        col_r     <= col_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_eoi_r  <= in_tuser;
    end
    if (s1_go && res_valid) begin
      out_cp_r     <= res_cp;
      out_line_r   <= line_out;
      out_col_r    <= col_out;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_col_r, out_line_r, out_cp_r};
  assign out_tuser  = out_status_r;

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line counter reached zero");

  a_col_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    col_r != '0)
    else $error("column counter reached zero");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'd5)
    else $error("continuation count out of range");

  a_err_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != utf8dec_pkg::ST_OK) |-> out_cp_r == '0)
    else $error("nonzero code point on error or end result");

  a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_eoi_r |=> rem_r == 3'd0 && !cr_r && !lf_r)
    else $error("end of input did not clear sequence state");

endmodule

// ===== sim/utf8_decoder_with_line_tracking_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_decoder_with_line_tracking_core_tb
// feeds byte streams into the decoder and checks each decoded character, with
// its line, column and status, against a decoder model kept in the bench.
// directed corner cases come first, then random well-formed and broken
// sequences under changing idle patterns, then a long output stall.
// ----------------------------------------------------------------------------
module utf8_decoder_with_line_tracking_core_tb;

  localparam int CYCLE_LIMIT = 100000;

  typedef struct {
    utf8dec_pkg::cp_t     cp;
    logic [31:0]          line;
    logic [31:0]          col;
    utf8dec_pkg::status_t st;
  } char_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] in_byte
  logic        in_tuser;   // [0] end_of_input
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;  // [30:0] code_point, [62:31] line_number,
                           // [94:63] column_number, [95] zero
  logic [1:0]  out_tuser;  // [1:0] status

  // decoder state mirrored by the bench
  utf8dec_pkg::cp_t seq_acc;
  logic [2:0]       seq_left;
  logic             prev_cr;
  logic             prev_lf;
  logic [31:0]      cur_line;
  logic [31:0]      cur_col;

  char_result_t decoded_chars[$];

  int fail_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  utf8_decoder_with_line_tracking_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic void push_result(input utf8dec_pkg::cp_t cp,
                                      input utf8dec_pkg::status_t st);
    char_result_t r;
    r.cp   = cp;
    r.line = cur_line;
    r.col  = cur_col;
    r.st   = st;
    decoded_chars.push_back(r);
  endfunction

  function automatic void advance_position(input utf8dec_pkg::cp_t cp);
    if ((cp == utf8dec_pkg::LF_CODE && !prev_cr) ||
        (cp == utf8dec_pkg::CR_CODE && !prev_lf)) begin
      cur_line = sat_inc(cur_line);
      cur_col  = 32'd1;
    end else begin
      cur_col = sat_inc(cur_col);
    end
    prev_cr = (cp == utf8dec_pkg::CR_CODE);
    prev_lf = (cp == utf8dec_pkg::LF_CODE);
    push_result(cp, utf8dec_pkg::ST_OK);
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eoi);
    utf8dec_pkg::cp_t cp;
    if (eoi) begin
      push_result('0, (seq_left != 0) ? utf8dec_pkg::ST_TRUNC : utf8dec_pkg::ST_END);
      seq_acc  = '0;
      seq_left = '0;
      prev_cr  = 1'b0;
      prev_lf  = 1'b0;
    end else if (seq_left != 0) begin
      seq_acc  = {seq_acc[utf8dec_pkg::CP_BITS-7:0], b[5:0]};
      seq_left = seq_left - 3'd1;
      if (seq_left == 0) begin
        cp      = seq_acc;
        seq_acc = '0;
        advance_position(cp);
      end
    end else if ((b & utf8dec_pkg::CONT_MASK) == 8'h00) begin
      advance_position(utf8dec_pkg::cp_t'(b));
    end else if ((b & utf8dec_pkg::LEAD6_MASK) == utf8dec_pkg::LEAD6_MASK) begin
      seq_acc  = utf8dec_pkg::cp_t'(b[1:0]);
      seq_left = 3'd5;
    end else if ((b & utf8dec_pkg::LEAD5_MASK) == utf8dec_pkg::LEAD5_MASK) begin
      seq_acc  = utf8dec_pkg::cp_t'(b[1:0]);
      seq_left = 3'd4;
    end else if ((b & utf8dec_pkg::LEAD4_MASK) == utf8dec_pkg::LEAD4_MASK) begin
      seq_acc  = utf8dec_pkg::cp_t'(b[2:0]);
      seq_left = 3'd3;
    end else if ((b & utf8dec_pkg::LEAD3_MASK) == utf8dec_pkg::LEAD3_MASK) begin
      seq_acc  = utf8dec_pkg::cp_t'(b[3:0]);
      seq_left = 3'd2;
    end else if ((b & utf8dec_pkg::LEAD2_MASK) == utf8dec_pkg::LEAD2_MASK) begin
      seq_acc  = utf8dec_pkg::cp_t'(b[4:0]);
      seq_left = 3'd1;
    end else begin
      push_result('0, utf8dec_pkg::ST_STRAY);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    char_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_chars.size() == 0) begin
        $error("unexpected result transfer: cp 0x%0h status %0d",
               out_tdata[30:0], out_tuser);
        fail_count++;
      end else begin
        want = decoded_chars.pop_front();
        check_field("code_point", 32'(want.cp), 32'(out_tdata[30:0]));
        check_field("line_number", want.line, out_tdata[62:31]);
        check_field("column_number", want.col, out_tdata[94:63]);
        check_field("status", 32'(want.st), 32'(out_tuser));
        check_field("pad", 32'd0, 32'(out_tdata[95]));
      end
    end
  end

  // result side: random stalls, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eoi);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(b, eoi);
  endtask

  function automatic logic [7:0] lead_byte(input int len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      2:       return utf8dec_pkg::LEAD2_MASK | (r & 8'h1F);
      3:       return utf8dec_pkg::LEAD3_MASK | (r & 8'h0F);
      4:       return utf8dec_pkg::LEAD4_MASK | (r & 8'h07);
      5:       return utf8dec_pkg::LEAD5_MASK | (r & 8'h03);
      default: return utf8dec_pkg::LEAD6_MASK | (r & 8'h03);
    endcase
  endfunction

  function automatic logic [7:0] ascii_byte();
    if ($urandom_range(3) == 0)
      return $urandom_range(1) ? utf8dec_pkg::LF_CODE[7:0] : utf8dec_pkg::CR_CODE[7:0];
    return 8'($urandom_range(127));
  endfunction

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(8'h00, 1'b0);
    // line breaks in the pairings cr-lf, lf-lf and lf-cr
    send_item(utf8dec_pkg::CR_CODE[7:0], 1'b0);
    send_item(utf8dec_pkg::LF_CODE[7:0], 1'b0);
    send_item(utf8dec_pkg::LF_CODE[7:0], 1'b0);
    send_item(utf8dec_pkg::CR_CODE[7:0], 1'b0);
    // stray continuation bytes, then well-formed two- and three-byte sequences
    send_item(8'h80, 1'b0);
    send_item(8'hBF, 1'b0);
    send_item(8'hC2, 1'b0);
    send_item(8'hA9, 1'b0);
    send_item(8'hE2, 1'b0);
    send_item(8'h82, 1'b0);
    send_item(8'hAC, 1'b0);
    // widest lead with lead-like trailing bytes, value clipped to 31 bits
    repeat (6) send_item(8'hFF, 1'b0);
    // end of input inside a sequence, then clean ends
    send_item(8'hF8, 1'b0);
    send_item(8'h41, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'h7F, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_random_stream(input int idle_pct, input int stall_pct,
                                    input int n_items);
    int sent;
    int kind;
    int len;
    int trail;
    sent           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        send_item(ascii_byte(), 1'b0);
        sent++;
      end else if (kind < 80) begin
        // well-formed sequence, or one with arbitrary trailing bytes
        len = $urandom_range(6, 2);
        send_item(lead_byte(len), 1'b0);
        repeat (len - 1) begin
          if (kind < 70)
            send_item(8'h80 | (8'($urandom) & utf8dec_pkg::LOW6_MASK), 1'b0);
          else send_item(8'($urandom_range(255)), 1'b0);
        end
        sent += len;
      end else if (kind < 87) begin
        len   = $urandom_range(6, 2);
        trail = $urandom_range(len - 2);
        send_item(lead_byte(len), 1'b0);
        repeat (trail)
          send_item(8'h80 | (8'($urandom) & utf8dec_pkg::LOW6_MASK), 1'b0);
        send_item(8'($urandom_range(255)), 1'b1);
        sent += trail + 2;
      end else if (kind < 92) begin
        send_item(8'($urandom_range(8'hBF, 8'h80)), 1'b0);
        sent++;
      end else if (kind < 96) begin
        send_item(8'($urandom_range(255)), 1'b1);
        sent++;
      end else begin
        send_item(8'($urandom_range(255)), 1'b0);
        sent++;
      end
    end
  endtask

  task automatic test_output_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left     <= 300;
    repeat (40) send_item(ascii_byte(), 1'b0);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = 8'h00;
    in_tuser       = 1'b0;
    out_tready     = 1'b0;
    fail_count     = 0;
    cycle_count    = 0;
    hold_left      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    seq_acc        = '0;
    seq_left       = '0;
    prev_cr        = 1'b0;
    prev_lf        = 1'b0;
    cur_line       = 32'd1;
    cur_col        = 32'd1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_stream(12, 62, 160);
    test_random_stream(62, 12, 160);
    test_random_stream(0, 0, 160);
    test_output_stall();

    in_tvalid <= 1'b0;
    while (decoded_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/utf8dec_pkg.sv
design/utf8_decoder_with_line_tracking_core.sv
sim/utf8_decoder_with_line_tracking_core_tb.sv
